/* hw/rtl/cdq_pkg.sv */
// Shared constants, codes and the cell control struct for the circular deque.
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int NCELL  = DEPTH - 1;
    localparam int CNT_W  = $clog2(DEPTH);

    localparam logic [2:0] F_PEEK       = 3'd0;
    localparam logic [2:0] F_PUSH_FRONT = 3'd1;
    localparam logic [2:0] F_PUSH_REAR  = 3'd2;
    localparam logic [2:0] F_POP_FRONT  = 3'd3;
    localparam logic [2:0] F_POP_REAR   = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              shift_in;
        logic              load_rear;
        logic              shift_out;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] wr_data;
    } dq_ctrl_t;

endpackage

/* hw/rtl/cdq_cell.sv */
// One storage cell of the deque row; shifts toward either neighbor or loads new data.
module cdq_cell
    import cdq_pkg::*;
(
    input  logic              aclk,
    input  dq_ctrl_t          ctrl,
    input  logic [CNT_W-1:0]  cell_idx,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data_out
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.shift_in) begin
            // cell 0 takes the new item, everyone else moves one place back
            data_next = (cell_idx == '0) ? ctrl.wr_data : left_data;
        end else if (ctrl.load_rear) begin
            if (cell_idx == ctrl.count) begin
                data_next = ctrl.wr_data;
            end
        end else if (ctrl.shift_out) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

/* hw/rtl/circular_deque.sv */
// Top level of the circular deque: cell row, fill count and registered result stage.
// Latency: the result of an item is on m_tdata the cycle after the item is accepted.
// Throughput: one item per cycle; s_tready stays high while the result register is
// empty or being drained, so only a stalled m_tready holds off the input.
// Reset: aresetn (synchronous, active low) clears the fill count and the result
// valid flag; cell contents are not reset and are only read once written.
module circular_deque
    import cdq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [2:0] func, [34:3] data_in, [39:35] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // m_tdata: [1:0] status, [33:2] front_data, [65:34] rear_data,
    //          [66] is_empty, [67] is_full, [71:68] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata
);

    // Entries live in cells 0..count-1, front in cell 0, rear in cell count-1.
    // Push front shifts the whole row back by one; pop front shifts it forward.
    // Push rear and pop rear touch only the count (and one cell on push).

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [DATA_W-1:0] cell_data [NCELL];
    dq_ctrl_t          ctrl;

    logic              accept;
    logic [2:0]        func;
    logic [DATA_W-1:0] wr_data;
    logic              empty_now;
    logic              full_now;
    logic              do_put_head;
    logic              do_put_tail;
    logic              do_take_head;
    logic              do_take_tail;
    logic [1:0]        status;
    logic [CNT_W-1:0]  rear_idx;
    logic [DATA_W-1:0] front_w;
    logic [DATA_W-1:0] rear_w;
    logic              empty_n;
    logic              full_n;

    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [1:0]        status_reg;
    logic [31:0]       front_reg;
    logic [31:0]       rear_reg;
    logic              empty_reg;
    logic              full_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign func     = s_tdata[2:0];
    assign wr_data  = DATA_W'(s_tdata[34:3]);

    assign empty_now = (count_reg == '0);
    assign full_now  = (count_reg == CNT_W'(NCELL));

    // Decode; rejected operations and unused codes fall through to peek.
    always_comb begin
        do_put_head  = 1'b0;
        do_put_tail  = 1'b0;
        do_take_head = 1'b0;
        do_take_tail = 1'b0;
        status       = ST_DONE;
        case (func)
            F_PUSH_FRONT: begin
                if (full_now) status = ST_FULL;
                else          do_put_head = 1'b1;
            end
            F_PUSH_REAR: begin
                if (full_now) status = ST_FULL;
                else          do_put_tail = 1'b1;
            end
            F_POP_FRONT: begin
                if (empty_now) status = ST_EMPTY;
                else           do_take_head = 1'b1;
            end
            F_POP_REAR: begin
                if (empty_now) status = ST_EMPTY;
                else           do_take_tail = 1'b1;
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (do_put_head || do_put_tail) begin
            count_next = count_reg + 1'b1;
        end else if (do_take_head || do_take_tail) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Cell controls only fire on an accepted item.
    assign ctrl.shift_in  = accept && do_put_head;
    assign ctrl.load_rear = accept && do_put_tail;
    assign ctrl.shift_out = accept && do_take_head;
    assign ctrl.count     = count_reg;
    assign ctrl.wr_data   = wr_data;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;
        if (i == 0) begin : g_first
            assign left_w = wr_data;
        end else begin : g_mid_l
            assign left_w = cell_data[i-1];
        end
        if (i == NCELL - 1) begin : g_last
            assign right_w = cell_data[i];
        end else begin : g_mid_r
            assign right_w = cell_data[i+1];
        end
        cdq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_idx   (CNT_W'(i)),
            .left_data  (left_w),
            .right_data (right_w),
            .data_out   (cell_data[i])
        );
    end

    // Result after the operation, taken from the row before it shifts.
    // Front: new item on push front or on a push into an empty deque,
    // old second entry on pop front.
    // Rear: one read port; pop rear looks one cell further down.
    assign rear_idx = do_take_tail ? (count_reg - CNT_W'(2)) : (count_reg - 1'b1);
    assign empty_n  = (count_next == '0);
    assign full_n   = (count_next == CNT_W'(NCELL));

    always_comb begin
        if (do_put_head || (do_put_tail && empty_now)) begin
            front_w = wr_data;
        end else if (do_take_head) begin
            front_w = cell_data[1];
        end else begin
            front_w = cell_data[0];
        end

        if (do_put_tail || (do_put_head && empty_now)) begin
            rear_w = wr_data;
        end else begin
            rear_w = cell_data[rear_idx];
        end

        if (empty_n) begin
            front_w = '0;
            rear_w  = '0;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload, loaded on acceptance and held while stalled.
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status;
            front_reg  <= 32'(front_w);
            rear_reg   <= 32'(rear_w);
            empty_reg  <= empty_n;
            full_reg   <= full_n;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, full_reg, empty_reg, rear_reg, front_reg, status_reg};

    // Fill count never passes the number of cells.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(NCELL))
        else $error("deque count beyond capacity");

    // A reported result is never both empty and full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(empty_reg && full_reg))
        else $error("empty and full flagged together");

    // A rejected push is only reported when full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && status_reg == ST_FULL) |-> full_reg)
        else $error("push rejected while not full");

    // A successful pop front removes exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && func == F_POP_FRONT && count_reg != '0)
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop front count mismatch");

endmodule

/* tb/circular_deque_checker.sv */
// Scoreboard for the circular deque: predicts each result and compares it.
module circular_deque_checker
    import cdq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          full_rejects,
    output int          empty_rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] front_data;
        logic [31:0] rear_data;
        logic        is_empty;
        logic        is_full;
    } dq_result_t;

    // shadow deque
    logic [DATA_W-1:0] shadow_slots [DEPTH];
    int                front_gap;   // slot just before the first entry
    int                last_slot;   // slot of the last entry
    dq_result_t        expected_results [$];
    int                n_fail, n_full_rej, n_empty_rej;

    function automatic bit shadow_empty();
        return front_gap == last_slot;
    endfunction

    function automatic bit shadow_full();
        return (last_slot + 1) % DEPTH == front_gap;
    endfunction

    function automatic dq_result_t apply_op(logic [2:0] op, logic [DATA_W-1:0] value);
        dq_result_t r;
        r.status = ST_DONE;
        case (op)
            F_PUSH_FRONT: begin
                if (shadow_full()) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_slots[front_gap] = value;
                    front_gap = (front_gap + DEPTH - 1) % DEPTH;
                end
            end
            F_PUSH_REAR: begin
                if (shadow_full()) begin
                    r.status = ST_FULL;
                end else begin
                    last_slot = (last_slot + 1) % DEPTH;
                    shadow_slots[last_slot] = value;
                end
            end
            F_POP_FRONT: begin
                if (shadow_empty()) r.status = ST_EMPTY;
                else front_gap = (front_gap + 1) % DEPTH;
            end
            F_POP_REAR: begin
                if (shadow_empty()) r.status = ST_EMPTY;
                else last_slot = (last_slot + DEPTH - 1) % DEPTH;
            end
            default: ;  // peek and unused codes
        endcase
        if (shadow_empty()) begin
            r.front_data = '0;
            r.rear_data  = '0;
        end else begin
            r.front_data = shadow_slots[(front_gap + 1) % DEPTH];
            r.rear_data  = shadow_slots[last_slot];
        end
        r.is_empty = shadow_empty();
        r.is_full  = shadow_full();
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        dq_result_t want;
        dq_result_t got;
        if (!aresetn) begin
            front_gap = DEPTH - 1;
            last_slot = DEPTH - 1;
            expected_results.delete();
            n_fail = 0;
            n_full_rej = 0;
            n_empty_rej = 0;
        end else begin
            // result side first: a result never belongs to an item taken this edge
            if (m_tvalid && m_tready) begin
                got.status     = m_tdata[1:0];
                got.front_data = m_tdata[33:2];
                got.rear_data  = m_tdata[65:34];
                got.is_empty   = m_tdata[66];
                got.is_full    = m_tdata[67];
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding: %0h", m_tdata);
                    n_fail++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("front_data", want.front_data, got.front_data);
                    compare_field("rear_data", want.rear_data, got.rear_data);
                    compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                    compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
                end
            end
            if (s_tvalid && s_tready) begin
                want = apply_op(s_tdata[2:0], s_tdata[34:3]);
                if (want.status == ST_FULL) n_full_rej++;
                if (want.status == ST_EMPTY) n_empty_rej++;
                expected_results.push_back(want);
            end
        end
        fail_count    <= n_fail;
        pending       <= expected_results.size();
        full_rejects  <= n_full_rej;
        empty_rejects <= n_empty_rej;
    end

endmodule

/* tb/circular_deque_test.sv */
// Top of the circular deque testbench: clock, reset, item stimulus and verdict.
module circular_deque_test;
    import cdq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 2000;
    // bound on the whole run; the worst case, long stalls included, stays far below this
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_STALL   = 200;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    int fail_count, pending, full_rejects, empty_rejects;
    int cycle_cnt    = 0;
    int items_sent   = 0;
    bit send_quiet   = 1'b0;   // stretch with no sender gaps
    bit accept_quiet = 1'b0;   // stretch with no receiver stalls

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    circular_deque DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    circular_deque_checker scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .full_rejects  (full_rejects),
        .empty_rejects (empty_rejects)
    );

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one item after a random gap; returns once the handshake has happened.
    // tvalid is left high so back-to-back items never drop it for a step.
    task automatic put_item(input logic [2:0] op, input logic [31:0] value);
        int gap;
        if ($urandom_range(0, 63) == 0) send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, value, op};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Sender pause: drop tvalid and hold until every result is back.
    task automatic drain_all();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // Receiver: random stall before every result, plus two long hold-offs
    // so the result register backs up and s_tready drops.
    initial begin : receiver
        int stall;
        int taken;
        taken = 0;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 63) == 0) accept_quiet = !accept_quiet;
            if (taken == 300 || taken == 1500) stall = LONG_STALL;
            else stall = accept_quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    initial begin : stimulus
        bit          filling;
        int          phase_left;
        int          pick;
        logic [2:0]  op;
        logic [31:0] value;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed: empty-deque corners, unused codes, both extremes of data
        put_item(F_PEEK, 32'h0);
        put_item(F_POP_FRONT, 32'hFFFF_FFFF);   // rejected, empty
        put_item(F_POP_REAR, 32'h0);            // rejected, empty
        put_item(3'd5, 32'h1234_5678);          // unused codes act as peek
        put_item(3'd6, 32'h0);
        put_item(3'd7, 32'hFFFF_FFFF);
        put_item(F_PUSH_FRONT, 32'hFFFF_FFFF);
        put_item(F_PUSH_REAR, 32'h0);
        put_item(F_POP_FRONT, 32'h0);
        put_item(F_POP_REAR, 32'h0);            // back to empty
        // fill to DEPTH-1 from both ends, so the pointers wrap
        for (int i = 0; i < NCELL; i++) begin
            put_item(i[0] ? F_PUSH_REAR : F_PUSH_FRONT,
                     i[1] ? 32'hAAAA_AAAA : 32'h5555_5555);
        end
        put_item(F_PUSH_FRONT, 32'hDEAD_BEEF);  // rejected, full
        put_item(F_PUSH_REAR, 32'hFFFF_FFFF);   // rejected, full
        drain_all();

        // --- random: alternate fill and drain phases so both ends of the
        // range are visited often, with some noise ops mixed in
        filling    = 1'b1;
        phase_left = $urandom_range(10, 40);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(10, 40);
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            if (pick < 6) op = 3'($urandom_range(0, 7));    // any code: peek, unused, push or pop
            else if ((pick < 81) == filling)
                op = $urandom_range(0, 1) ? F_PUSH_FRONT : F_PUSH_REAR;
            else
                op = $urandom_range(0, 1) ? F_POP_FRONT : F_POP_REAR;
            case ($urandom_range(0, 15))
                0:       value = 32'h0;
                1:       value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            put_item(op, value);
            if (n == RANDOM_ITEMS / 2) drain_all();
        end

        drain_all();
        repeat (4) @(posedge aclk);

        $display("Covered %0d items over fill and drain phases, random idling on both sides",
                 items_sent);
        $display("  %0d pushes refused on a full deque, %0d pops refused on an empty one",
                 full_rejects, empty_rejects);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_cell.sv
hw/rtl/circular_deque.sv
tb/circular_deque_checker.sv
tb/circular_deque_test.sv
